// File: rtl/spr_pkg.sv
package spr_pkg;

  localparam int POS_W      = 32;
  localparam int HEIGHT_W   = 32;
  localparam int SLOPE_W    = 24;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = POS_W + SLOPE_W;
  localparam int DROP_W     = PROD_W - FRAC_SHIFT;
  localparam int DIFF_W     = DROP_W + 2;

  typedef struct packed {
    logic [POS_W-1:0]           position;
    logic signed [HEIGHT_W-1:0] height;
    logic                       last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] adjusted_height;
    logic                       last_result;
  } result_t;

  // one sweep read issued towards the store
  typedef struct packed {
    logic valid;
    logic init;
    logic backward;
  } sweep_op_t;

endpackage

// File: rtl/spr_store.sv
module spr_store
  import spr_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       pos_we,
  input  logic                       height_we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [POS_W-1:0]           wr_pos,
  input  logic signed [HEIGHT_W-1:0] wr_height,
  input  logic [AW-1:0]              rd_addr,
  output logic [POS_W-1:0]           rd_pos,
  output logic signed [HEIGHT_W-1:0] rd_height
);

  logic [POS_W-1:0]           pos_mem    [DEPTH];
  logic signed [HEIGHT_W-1:0] height_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= wr_pos;
    end
    rd_pos <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (height_we) begin
      height_mem[wr_addr] <= wr_height;
    end
    rd_height <= height_mem[rd_addr];
  end

endmodule

// File: rtl/spr_sweep.sv
module spr_sweep
  import spr_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sweep_op_t                  op,
  input  logic [AW-1:0]              op_addr,
  input  logic [SLOPE_W-1:0]         slope,
  input  logic [POS_W-1:0]           rd_pos,
  input  logic signed [HEIGHT_W-1:0] rd_height,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic signed [HEIGHT_W-1:0] wr_height,
  output logic                       busy
);

  sweep_op_t                  b_op;
  sweep_op_t                  c_op;
  logic [AW-1:0]              b_addr;
  logic [AW-1:0]              c_addr;
  logic signed [HEIGHT_W-1:0] c_height;
  logic [PROD_W-1:0]          c_prod;
  logic [POS_W-1:0]           p_prev;
  logic signed [HEIGHT_W-1:0] h_adj;

  logic [POS_W-1:0]           p_hi;
  logic [POS_W-1:0]           p_lo;
  logic [POS_W-1:0]           du;
  logic signed [DIFF_W-1:0]   diff;
  logic                       under;
  logic signed [HEIGHT_W-1:0] floor_h;
  logic                       raise;

  // stage b: position step towards the neighbour, times slope
  always_comb begin
    p_hi = b_op.backward ? p_prev : rd_pos;
    p_lo = b_op.backward ? rd_pos : p_prev;
    du   = (p_hi > p_lo) ? (p_hi - p_lo) : '0;
  end

  // stage c: neighbour minus drop, saturated low, then raise
  always_comb begin
    diff    = DIFF_W'(h_adj) - $signed({2'b00, c_prod[PROD_W-1:FRAC_SHIFT]});
    under   = diff[DIFF_W-1:HEIGHT_W-1] != {(DIFF_W-HEIGHT_W+1){diff[DIFF_W-1]}};
    floor_h = under ? $signed({1'b1, {(HEIGHT_W-1){1'b0}}}) : diff[HEIGHT_W-1:0];
    raise   = c_height < floor_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_op <= '0;
      c_op <= '0;
    end else begin
      b_op <= op;
      c_op <= b_op;
    end
    b_addr   <= op_addr;
    c_addr   <= b_addr;
    c_height <= rd_height;
    c_prod   <= PROD_W'(du) * PROD_W'(slope);
    if (b_op.valid) begin
      p_prev <= rd_pos;
    end
    if (c_op.valid) begin
      h_adj <= (c_op.init || !raise) ? c_height : floor_h;
    end
  end

  assign wr_en     = c_op.valid && !c_op.init && raise;
  assign wr_addr   = c_addr;
  assign wr_height = floor_h;
  assign busy      = b_op.valid || c_op.valid;

endmodule

// File: rtl/spr_emit.sv
module spr_emit
  import spr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  logic                       issue_last,
  input  logic signed [HEIGHT_W-1:0] rd_height,
  output logic                       can_issue,
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result
);

  logic    fly;
  logic    fly_last;
  logic    skid_valid;
  result_t skid_word;
  result_t arr_word;
  logic    pop;
  logic [1:0] occ;

  assign arr_word  = '{adjusted_height: rd_height, last_result: fly_last};
  assign pop       = result_valid && !result_stall;
  assign occ       = 2'(fly) + 2'(result_valid) + 2'(skid_valid);
  // a read may go out if its word has a register to land in
  assign can_issue = (occ < 2'd2) || (occ == 2'd2 && pop);

  always_ff @(posedge clk) begin
    fly_last <= issue_last;
    if (rst) begin
      fly          <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      fly <= issue;
      if (!result_valid || pop) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          result       <= skid_word;
          skid_valid   <= fly;
          skid_word    <= arr_word;
        end else begin
          result_valid <= fly;
          result       <= arr_word;
        end
      end else if (fly) begin
        skid_valid <= 1'b1;
        skid_word  <= arr_word;
      end
    end
  end

endmodule

// File: rtl/slope_limited_profile_raise.sv
// channel  | handshake                 | word
// ---------+---------------------------+-----------------------------------------
// sample   | sample_valid/sample_stall | position, height, last_sample
// result   | result_valid/result_stall | adjusted_height, last_result
// slope    | slope_valid/slope_ready   | max_slope, q8.16 (ready is always high)
//
// loading takes one cycle per sample; the closing sample starts the sweeps
// forward and backward sweeps each run through the store read port and the
// multiply/subtract pipeline; emission issues one word per cycle while can_issue
// is high; sweeps skipped for n = 1 or max_slope = 0; no new sample is taken
// until the last read is out
// synchronous reset clears control and max_slope; the stores are not cleared
// result_stall holds the output register and a skid word, it never loses data
module slope_limited_profile_raise
  import spr_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               slope_valid,
  output logic               slope_ready,
  input  logic [SLOPE_W-1:0] slope_data
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FWD,
    ST_FWD_WAIT,
    ST_BWD,
    ST_BWD_WAIT,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;      // samples held so far
  logic [CW-1:0]      n;          // size of the closed profile
  logic [AW-1:0]      k;          // read pointer for sweeps and emission
  logic [SLOPE_W-1:0] max_slope;

  logic          load_we;
  logic          closing;
  logic [CW-1:0] n_last;
  logic [AW-1:0] k_last;

  sweep_op_t                  sw_op;
  logic                       sw_wr_en;
  logic [AW-1:0]              sw_wr_addr;
  logic signed [HEIGHT_W-1:0] sw_wr_height;
  logic                       sw_busy;

  logic [POS_W-1:0]           rd_pos;
  logic signed [HEIGHT_W-1:0] rd_height;

  logic emit_issue;
  logic emit_last;
  logic can_issue;

  assign sample_stall = state != ST_LOAD;
  assign slope_ready  = 1'b1;
  assign load_we      = sample_valid && !sample_stall;
  // a full store closes the profile just like a marked last sample
  assign closing      = load_we && (sample.last_sample || count == CW'(MAX_SAMPLES - 1));
  assign n_last       = n - CW'(1);
  assign k_last       = n_last[AW-1:0];

  always_comb begin
    sw_op.valid    = state == ST_FWD || state == ST_BWD;
    sw_op.backward = state == ST_BWD;
    // the first entry of each sweep only seeds the neighbour registers
    sw_op.init     = (state == ST_BWD) ? (k == k_last) : (k == '0);
  end

  assign emit_issue = state == ST_EMIT && can_issue;
  assign emit_last  = k == k_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slope <= '0;
    end else if (slope_valid) begin
      max_slope <= slope_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      n     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (closing) begin
            n     <= count + CW'(1);
            count <= '0;
            k     <= '0;
            // single sample or clamping off: straight to output
            if (count == '0 || max_slope == '0) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_FWD;
            end
          end else if (load_we) begin
            count <= count + CW'(1);
          end
        end
        ST_FWD: begin
          k <= k + AW'(1);
          if (k == k_last) begin
            state <= ST_FWD_WAIT;
          end
        end
        ST_FWD_WAIT: begin
          // let the last forward write land before reading backward
          if (!sw_busy) begin
            k     <= k_last;
            state <= ST_BWD;
          end
        end
        ST_BWD: begin
          k <= k - AW'(1);
          if (k == '0) begin
            state <= ST_BWD_WAIT;
          end
        end
        ST_BWD_WAIT: begin
          if (!sw_busy) begin
            k     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_issue) begin
            k <= k + AW'(1);
            if (emit_last) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  spr_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .pos_we    (load_we),
    .height_we (load_we || sw_wr_en),
    .wr_addr   (load_we ? count[AW-1:0] : sw_wr_addr),
    .wr_pos    (sample.position),
    .wr_height (load_we ? sample.height : sw_wr_height),
    .rd_addr   (k),
    .rd_pos    (rd_pos),
    .rd_height (rd_height)
  );

  spr_sweep #(
    .AW (AW)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .op        (sw_op),
    .op_addr   (k),
    .slope     (max_slope),
    .rd_pos    (rd_pos),
    .rd_height (rd_height),
    .wr_en     (sw_wr_en),
    .wr_addr   (sw_wr_addr),
    .wr_height (sw_wr_height),
    .busy      (sw_busy)
  );

  spr_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .issue        (emit_issue),
    .issue_last   (emit_last),
    .rd_height    (rd_height),
    .can_issue    (can_issue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(load_we && sw_wr_en))
    else $error("sweep write collides with sample load");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    sw_wr_en |-> sw_wr_addr <= k_last)
    else $error("sweep write beyond profile");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    sw_busy |-> (state != ST_LOAD && state != ST_EMIT))
    else $error("sweep pipeline active outside sweep phase");

  a_close_to_load: assert property (@(posedge clk) disable iff (rst)
    (emit_issue && emit_last) |=> (state == ST_LOAD && count == '0))
    else $error("profile did not return to loading after last read");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spr_pkg::*;

  localparam int MAX_SAMPLES     = 64;
  // drain margin long enough for the longest full profile
  localparam int DRAIN_CYCLES    = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int REPORT_CAP      = 40;

  // expected raised heights, worked out profile by profile as samples go in
  class envelope_board;
    logic [POS_W-1:0]           pos_held [MAX_SAMPLES];
    logic signed [HEIGHT_W-1:0] height_held [MAX_SAMPLES];
    int                         held;
    result_t                    raised_words [$];
    int                         errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    // lowest height a sample may take given its neighbour and the step between them
    function logic signed [HEIGHT_W-1:0] floor_from(logic signed [HEIGHT_W-1:0] nb,
                                                    logic [POS_W-1:0] p_from,
                                                    logic [POS_W-1:0] p_to,
                                                    logic [SLOPE_W-1:0] slope);
      logic [POS_W-1:0] du;
      logic [63:0]      drop;
      longint           f;
      du = (p_to > p_from) ? p_to - p_from : '0;
      drop = (64'(du) * 64'(slope)) >> FRAC_SHIFT;
      f = longint'(nb) - longint'(drop);
      if (f < -64'sd2147483648) f = -64'sd2147483648;
      if (f > 64'sd2147483647) f = 64'sd2147483647;
      return HEIGHT_W'(f);
    endfunction

    function void raise_profile(logic [SLOPE_W-1:0] slope);
      logic signed [HEIGHT_W-1:0] f;
      for (int i = 1; i < held; i++) begin
        f = floor_from(height_held[i-1], pos_held[i-1], pos_held[i], slope);
        if (height_held[i] < f) height_held[i] = f;
      end
      for (int i = held - 2; i >= 0; i--) begin
        f = floor_from(height_held[i+1], pos_held[i], pos_held[i+1], slope);
        if (height_held[i] < f) height_held[i] = f;
      end
    endfunction

    function void take_sample(sample_t s, logic [SLOPE_W-1:0] slope);
      result_t r;
      pos_held[held] = s.position;
      height_held[held] = s.height;
      held++;
      if (s.last_sample || held == MAX_SAMPLES) begin
        if (held >= 2 && slope != '0) raise_profile(slope);
        for (int k = 0; k < held; k++) begin
          r.adjusted_height = height_held[k];
          r.last_result = (k == held - 1);
          raised_words.push_back(r);
        end
        held = 0;
      end
    endfunction

    function void note_error(string field, longint want, longint got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (raised_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result word with none expected, expected none actual %0d/%0d",
                   $time, got.adjusted_height, got.last_result);
        return;
      end
      want = raised_words.pop_front();
      if (got.adjusted_height !== want.adjusted_height)
        note_error("adjusted_height", want.adjusted_height, got.adjusted_height);
      if (got.last_result !== want.last_result)
        note_error("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  sample_t            sample_word = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result_word;
  logic               slope_valid = 1'b0;
  logic               slope_ready;
  logic [SLOPE_W-1:0] slope_data = '0;

  envelope_board board;
  // slope the block holds, as far as the writes go
  logic [SLOPE_W-1:0] slope_now = '0;

  // idling knobs, set per phase by the stimulus
  bit quiet = 1'b0;
  int gap_pct = 0;
  int busy_pct = 0;

  // long receiver hold-off, asked by the stimulus and served by the receiver
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  int cycles = 0;

  slope_limited_profile_raise #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result_word),
    .slope_valid (slope_valid),
    .slope_ready (slope_ready),
    .slope_data  (slope_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: check each accepted word, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result_word);
    if (hold_served != hold_asks) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(99) < busy_pct) begin
      // start a stall burst, counting this cycle as its first
      stall_left = $urandom_range(1, 7) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic sample_t mk(logic [POS_W-1:0] p, logic [HEIGHT_W-1:0] h, bit last);
    sample_t s;
    s.position = p;
    s.height = h;
    s.last_sample = last;
    return s;
  endfunction

  // offer one sample word, maybe after a gap, and hold it until taken
  task automatic send_word(input sample_t s);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word <= s;
    do @(posedge clk); while (sample_stall);
    board.take_sample(s, slope_now);
  endtask

  // block idle: nothing owed, and time for any sweep still running
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (board.raised_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slope(input logic [SLOPE_W-1:0] v);
    wait_drained();
    slope_valid <= 1'b1;
    slope_data <= v;
    do @(posedge clk); while (!slope_ready);
    slope_valid <= 1'b0;
    slope_now = v;
  endtask

  // one profile: mostly a walk with rising positions and wandering heights,
  // sometimes raw noise; close_it = 0 with len 64 leaves closing to the full store
  task automatic run_profile(input int len, input bit close_it, input bit noisy);
    logic [POS_W-1:0] p;
    int               h;
    sample_t          s;
    p = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
    h = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        s.position = $urandom;
        s.height = $urandom;
      end else begin
        case ($urandom_range(9))
          0:       p = p;                                  // zero step
          1:       p = p - $urandom_range(0, 32'h400);     // backwards step
          default: p = p + $urandom_range(1, 32'h800);
        endcase
        case ($urandom_range(11))
          0:       h = int'($urandom);
          1:       h = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          2:       h = h - int'($urandom_range(0, 32'h4_0000));  // deep dip
          default: h = h + int'($urandom_range(0, 32'h2000)) - 32'h1000;
        endcase
        s.position = p;
        s.height = h;
      end
      s.last_sample = close_it && (i == len - 1);
      send_word(s);
    end
  endtask

  task automatic run_random_phase(input int phase);
    int items;
    int len;
    int pick;
    items = 0;
    if (phase == NUM_PHASES - 1) begin
      quiet = 1'b1;
    end else begin
      pick = $urandom_range(2);
      gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      pick = $urandom_range(2);
      busy_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
    end
    // the receiver sits still while profiles keep coming, so the block backs up
    if (phase == 1) hold_asks++;
    // a profile that only the full store closes
    if (phase == 3) begin
      run_profile(MAX_SAMPLES, 1'b0, 1'b0);
      items += MAX_SAMPLES;
    end
    while (items < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 96) len = $urandom_range(9, 24);
      else                len = MAX_SAMPLES;
      run_profile(len, (len < MAX_SAMPLES) || ($urandom_range(1) == 1),
                  $urandom_range(99) < 15);
      items += len;
    end
  endtask

  initial begin
    logic [SLOPE_W-1:0] phase_slope [NUM_PHASES];
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // clamping off at reset: a steep drop passes as is
    send_word(mk(32'h0, 32'h7FFF_FFFF, 1'b0));
    send_word(mk(32'hFFFF_FFFF, 32'h8000_0000, 1'b1));

    // steepest slope, one-sample profile passes through
    write_slope(24'hFFFF_FF);
    send_word(mk(32'hFFFF_FFFF, 32'h8000_0000, 1'b1));

    // floor saturates at the bottom; equal and falling positions count as no step
    send_word(mk(32'h0, 32'h7FFF_FFFF, 1'b0));
    send_word(mk(32'hFFFF_FFFF, 32'h8000_0000, 1'b0));
    send_word(mk(32'h0, 32'h8000_0000, 1'b0));
    send_word(mk(32'h0, 32'h0, 1'b1));

    // unit slope, both sweeps do work
    write_slope(24'h01_0000);
    send_word(mk(32'h000, 32'h0001_0000, 1'b0));
    send_word(mk(32'h100, 32'h0000_0000, 1'b0));
    send_word(mk(32'h200, 32'hFFFF_0000, 1'b0));
    send_word(mk(32'h300, 32'h0002_0000, 1'b1));

    // slope changes while a profile is open, the closing value counts
    send_word(mk(32'h1000, 32'h0010_0000, 1'b0));
    send_word(mk(32'h9000, 32'hFFF0_0000, 1'b0));
    send_word(mk(32'h9000, 32'h0000_0000, 1'b0));
    write_slope(24'h00_0001);
    send_word(mk(32'h0FFF_0000, 32'h8000_0000, 1'b1));

    phase_slope[0] = 24'h00_0100;
    phase_slope[1] = 24'h01_0000;
    phase_slope[2] = 24'h00_0000;
    phase_slope[3] = 24'hFF_FFFF;
    phase_slope[4] = SLOPE_W'($urandom);
    phase_slope[5] = 24'h00_4000;
    phase_slope[6] = SLOPE_W'($urandom);
    phase_slope[7] = 24'h02_0000;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_slope(phase_slope[ph]);
      run_random_phase(ph);
    end

    wait_drained();
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/spr_pkg.sv
rtl/spr_store.sv
rtl/spr_sweep.sv
rtl/spr_emit.sv
rtl/slope_limited_profile_raise.sv
dv/tb_top.sv
